// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. All checks run on clk_i and are
// switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/rle_pkg.sv
package rle_pkg;

  localparam int COUNT_DIGITS = 10;
  localparam int DIGIT_W = 4;
  localparam int CNT_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
  localparam logic [CNT_W-1:0] DIGIT_TOP = CNT_W'(COUNT_DIGITS - 1);

  localparam logic [DIGIT_W-1:0] BCD_NINE = DIGIT_W'(9);
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       end_of_message;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INC,
    S_EMIT_BYTE,
    S_EMIT_DIGIT
  } state_e;

  // Operations on the digit shift register.
  typedef enum logic [2:0] {
    DOP_HOLD,
    DOP_ROT_UP,
    DOP_SHIFT_DN,
    DOP_LOAD_ONE,
    DOP_CLEAR
  } dig_op_e;

  typedef struct packed {
    dig_op_e op;
    digit_t  new_digit;
  } dig_ctl_t;

endpackage

// File: sv/rle_decimal_count_encoder_unit.sv
// Run-length encoder with a decimal run counter.
// Input channel: in_valid_i / in_stall_o / in_data_i carry one message byte and
// a flag on the final byte. Output channel: out_valid_o / out_stall_i /
// out_data_o carry encoded bytes: the run byte, then the run length as ASCII
// decimal digits, most significant first, without leading zeros.
// The run length is a BCD counter held in a digit shift register that is
// walked one digit per cycle to increment or emit it; the emission walk can
// pause on an output stall. An input that only extends a run is taken while
// the block is idle, and the input then stalls during the increment walk.
// Emitting a run sends the run byte, then walks the digits; a byte that closes
// a run and is also final emits two runs. An input that opens a run without
// ending the message is ready again on the next cycle.
// After a closing input is accepted the block enters S_EMIT_BYTE, which
// registers the run byte once the output can load; a final byte that extends
// its run passes through S_INC first.
// While out_stall_i is high and the output register is valid, it holds its
// transaction and the digit walk pauses on every digit that must be sent;
// skipped leading zeros still advance.
// Reset clears the run state, the counter and the output valid bit; the block
// is ready for a message in the first cycle after reset.
`include "assert_macros.svh"

module rle_decimal_count_encoder_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rle_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rle_pkg::out_t out_data_o
);
  import rle_pkg::*;

  state_e             state_q, state_d;
  logic [7:0]         run_byte_q, run_byte_d;
  logic               run_open_q, run_open_d;
  logic               full_q, full_d;
  in_t                item_q, item_d;
  logic               reload_q, reload_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               seen_q, seen_d;
  logic               carry_q, carry_d;
  logic               nine_q, nine_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  dig_ctl_t           dig_ctl;
  digit_t             msd, lsd;
  digit_t             inc_digit;
  logic               can_load;
  logic               show;
  logic               walk_end;

  rle_digit_shift u_digits (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dig_ctl),
    .msd_o  (msd),
    .lsd_o  (lsd)
  );

  assign can_load  = !out_valid_q || !out_stall_i;
  assign walk_end  = (cnt_q == DIGIT_TOP);
  assign show      = (msd != '0) || seen_q || walk_end;
  assign inc_digit = !carry_q ? lsd : ((lsd == BCD_NINE) ? '0 : lsd + DIGIT_W'(1));

  always_comb begin
    state_d     = state_q;
    run_byte_d  = run_byte_q;
    run_open_d  = run_open_q;
    full_d      = full_q;
    item_d      = item_q;
    reload_d    = reload_q;
    cnt_d       = cnt_q;
    seen_d      = seen_q;
    carry_d     = carry_q;
    nine_d      = nine_q;
    out_d       = out_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    dig_ctl     = '{op: DOP_HOLD, new_digit: '0};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          cnt_d   = '0;
          seen_d  = 1'b0;
          carry_d = 1'b1;
          nine_d  = 1'b1;
          if (!run_open_q) begin
            run_byte_d  = in_data_i.data_byte;
            dig_ctl.op  = DOP_LOAD_ONE;
            full_d      = 1'b0;
            run_open_d  = 1'b1;
            reload_d    = 1'b0;
            state_d     = in_data_i.final_byte ? S_EMIT_BYTE : S_IDLE;
          end else if (in_data_i.data_byte == run_byte_q && !full_q) begin
            reload_d = 1'b0;
            state_d  = S_INC;
          end else begin
            // Close the current run, then restart it with the new byte.
            reload_d = 1'b1;
            state_d  = S_EMIT_BYTE;
          end
        end
      end
      S_INC: begin
        dig_ctl = '{op: DOP_SHIFT_DN, new_digit: inc_digit};
        carry_d = carry_q && (lsd == BCD_NINE);
        nine_d  = nine_q && (inc_digit == BCD_NINE);
        cnt_d   = cnt_q + 1'b1;
        if (walk_end) begin
          full_d  = nine_q && (inc_digit == BCD_NINE);
          state_d = item_q.final_byte ? S_EMIT_BYTE : S_IDLE;
        end
      end
      S_EMIT_BYTE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{code_byte: run_byte_q, last_of_item: 1'b0, end_of_message: 1'b0};
          cnt_d       = '0;
          seen_d      = 1'b0;
          state_d     = S_EMIT_DIGIT;
        end
      end
      S_EMIT_DIGIT: begin
        if (!show || can_load) begin
          if (show) begin
            out_valid_d = 1'b1;
            out_d.code_byte      = ASCII_ZERO + {4'b0000, msd};
            out_d.last_of_item   = walk_end && (!reload_q || !item_q.final_byte);
            out_d.end_of_message = walk_end && !reload_q;
          end
          dig_ctl.op = DOP_ROT_UP;
          seen_d     = seen_q || (msd != '0);
          cnt_d      = cnt_q + 1'b1;
          if (walk_end) begin
            full_d = 1'b0;
            if (reload_q) begin
              run_byte_d = item_q.data_byte;
              dig_ctl.op = DOP_LOAD_ONE;
              reload_d   = 1'b0;
              state_d    = item_q.final_byte ? S_EMIT_BYTE : S_IDLE;
            end else begin
              dig_ctl.op = DOP_CLEAR;
              run_open_d = 1'b0;
              state_d    = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_byte_q  <= '0;
      run_open_q  <= 1'b0;
      full_q      <= 1'b0;
      reload_q    <= 1'b0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      carry_q     <= 1'b0;
      nine_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_byte_q  <= run_byte_d;
      run_open_q  <= run_open_d;
      full_q      <= full_d;
      reload_q    <= reload_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      carry_q     <= carry_d;
      nine_q      <= nine_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLIES(a_eom_is_last, out_valid_q && out_q.end_of_message, out_q.last_of_item, "end of message without last of item")
  `ASSERT_IMPLIES(a_full_needs_run, full_q, run_open_q, "counter full while no run is open")
  `ASSERT_IMPLIES(a_emit_needs_run, state_q == S_EMIT_DIGIT || state_q == S_EMIT_BYTE, run_open_q, "emitting with no open run")
  `ASSERT_ALWAYS(a_reload_only_emit, !reload_q || state_q == S_EMIT_BYTE || state_q == S_EMIT_DIGIT, "run restart pending outside emission")

endmodule

// File: sv/rle_digit_shift.sv
module rle_digit_shift (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rle_pkg::dig_ctl_t  ctl_i,
  output rle_pkg::digit_t    msd_o,
  output rle_pkg::digit_t    lsd_o
);
  import rle_pkg::*;

  // Entry 0 holds the least significant digit.
  digit_t dig_q [COUNT_DIGITS];
  digit_t dig_d [COUNT_DIGITS];

  always_comb begin
    dig_d = dig_q;
    unique case (ctl_i.op)
      DOP_HOLD: begin
      end
      DOP_ROT_UP: begin
        // The most significant digit wraps around to the bottom.
        for (int i = 1; i < COUNT_DIGITS; i++) begin
          dig_d[i] = dig_q[i-1];
        end
        dig_d[0] = dig_q[COUNT_DIGITS-1];
      end
      DOP_SHIFT_DN: begin
        // The updated least significant digit enters at the top.
        for (int i = 0; i < COUNT_DIGITS - 1; i++) begin
          dig_d[i] = dig_q[i+1];
        end
        dig_d[COUNT_DIGITS-1] = ctl_i.new_digit;
      end
      DOP_LOAD_ONE: begin
        for (int i = 0; i < COUNT_DIGITS; i++) begin
          dig_d[i] = '0;
        end
        dig_d[0] = DIGIT_W'(1);
      end
      DOP_CLEAR: begin
        for (int i = 0; i < COUNT_DIGITS; i++) begin
          dig_d[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COUNT_DIGITS; i++) begin
        dig_q[i] <= '0;
      end
    end else begin
      dig_q <= dig_d;
    end
  end

  assign msd_o = dig_q[COUNT_DIGITS-1];
  assign lsd_o = dig_q[0];

endmodule
